### src/piaqm_pkg.sv
// ============================================================================
// piaqm_pkg: shared definitions for the PI drop controller
// Field widths, register indexes, reset values, verdict codes and the
// command and status words between the controller and the datapath.
// ============================================================================
package piaqm_pkg;

	localparam int QLEN_BITS_DEF      = 24;
	localparam int PROB_FRAC_BITS_DEF = 32;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int LIMIT_W    = 24;
	localparam int REF_W      = 32;
	localparam int COEF_W     = 32;
	localparam int MEAN_W     = 16;
	localparam int SIZE_W     = 16;
	localparam int RAND_W     = 32;
	localparam int CNT_W      = 32;
	localparam int VERDICT_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BYTE_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_REF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_SIZE   = 3'd5;

	localparam logic [LIMIT_W-1:0] LIMIT_RST  = 24'd25;
	localparam logic [REF_W-1:0]   REF_RST    = 32'd3276800;
	localparam logic [COEF_W-1:0]  COEF_A_RST = 32'd78254;
	localparam logic [COEF_W-1:0]  COEF_B_RST = 32'd77997;
	localparam logic [MEAN_W-1:0]  MEAN_RST   = 16'd500;

	localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_FORCED = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_EARLY  = 2'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_TICK   = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_DIV_QN,
		OP_DIV_QO,
		OP_DIV_PE,
		OP_TAKE_QN,
		OP_TAKE_QO,
		OP_ERR_A,
		OP_ERR_B,
		OP_MUL_HI,
		OP_MUL_LO,
		OP_TERM,
		OP_ACC,
		OP_DIFF,
		OP_CLAMP,
		OP_FORCE_CHK,
		OP_DROP_FORCED,
		OP_MUL_P,
		OP_TAKE_PE,
		OP_DECIDE,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		logic   load;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic tick;
		logic byte_mode;
		logic forced;
		logic div_busy;
	} dp_sts_t;

endpackage

### src/piaqm_div.sv
// ============================================================================
// piaqm_div: serial restoring divider
// Produces one quotient bit per cycle, most significant first. The quotient
// is valid once busy falls and holds until the next start.
// ============================================================================
module piaqm_div #(
	parameter int DIVIDEND_W = piaqm_pkg::PROB_FRAC_BITS_DEF + 17,
	parameter int DIVISOR_W  = piaqm_pkg::MEAN_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);
	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  dsr_q;

	logic [DIVISOR_W:0] rem_sh;
	logic [DIVISOR_W:0] rem_sub;
	logic               fits;

	// The running remainder stays below the divisor, so one shifted-in bit
	// needs only one extra bit of headroom.
	assign rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits    = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIVIDEND_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

### src/piaqm_dp.sv
// ============================================================================
// piaqm_dp: datapath of the PI drop controller
// Configuration registers, controller state, the shared serial divider, the
// multiplier and the accumulators. Each cycle it carries out one command.
// ============================================================================
module piaqm_dp #(
	parameter int QLEN_BITS      = piaqm_pkg::QLEN_BITS_DEF,
	parameter int PROB_FRAC_BITS = piaqm_pkg::PROB_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  piaqm_pkg::dp_cmd_t                cmd,
	output piaqm_pkg::dp_sts_t                sts,
	input  logic                              cfg_wr_en,
	input  logic [piaqm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [piaqm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              op,
	input  logic [QLEN_BITS-1:0]              queue_len,
	input  logic [piaqm_pkg::SIZE_W-1:0]      pkt_size,
	input  logic [piaqm_pkg::RAND_W-1:0]      random_u,
	output logic [piaqm_pkg::VERDICT_W-1:0]   verdict,
	output logic [PROB_FRAC_BITS:0]           prob_now,
	output logic [piaqm_pkg::CNT_W-1:0]       forced_total,
	output logic [piaqm_pkg::CNT_W-1:0]       early_total
);
	import piaqm_pkg::*;

	localparam int NORM_W  = QLEN_BITS + 16;
	localparam int PROB_W  = PROB_FRAC_BITS + 1;
	localparam int PROD_W  = PROB_W + SIZE_W;
	localparam int DIV_W   = (NORM_W > PROD_W) ? NORM_W : PROD_W;
	localparam int MAG_W   = (NORM_W > REF_W) ? NORM_W : REF_W;
	localparam int HI_W    = MAG_W - 16;
	localparam int T_W     = MAG_W + 16;
	localparam int Y_W     = COEF_W + 16;
	localparam int ACC_W   = T_W + 2;
	localparam int ALIGN   = 32 - PROB_FRAC_BITS;
	localparam int CMP_W   = ((QLEN_BITS > SIZE_W) ? QLEN_BITS : SIZE_W) + 1;
	localparam logic [PROB_W-1:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

	// Configuration
	logic              byte_mode_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [REF_W-1:0]   ref_q;
	logic [COEF_W-1:0]  coef_a_q;
	logic [COEF_W-1:0]  coef_b_q;
	logic [MEAN_W-1:0]  mean_q;

	// Controller state
	logic [PROB_W-1:0]    prob_q;
	logic [QLEN_BITS-1:0] prev_q;
	logic [CNT_W-1:0]     forced_cnt_q;
	logic [CNT_W-1:0]     early_cnt_q;

	// Item and work registers
	logic                 tick_q;
	logic [QLEN_BITS-1:0] qlen_q;
	logic [SIZE_W-1:0]    size_q;
	logic [RAND_W-1:0]    rand_q;
	logic [NORM_W-1:0]    qn_q;
	logic [NORM_W-1:0]    qo_q;
	logic [MAG_W-1:0]     mag_q;
	logic                 to_pos_q;
	logic                 use_b_q;
	logic [T_W-1:0]       x_q;
	logic [Y_W-1:0]       y_q;
	logic [T_W-1:0]       t_q;
	logic [ACC_W-1:0]     pos_q;
	logic [ACC_W-1:0]     neg_q;
	logic [ACC_W:0]       diff_q;
	logic                 forced_q;
	logic [PROD_W-1:0]    prod_q;
	logic [PROB_W-1:0]    pe_q;
	logic [VERDICT_W-1:0] verdict_q;

	// Result word
	logic [VERDICT_W-1:0] out_verdict_q;
	logic [PROB_W-1:0]    out_prob_q;
	logic [CNT_W-1:0]     out_forced_q;
	logic [CNT_W-1:0]     out_early_q;

	// Combinational helpers
	logic [NORM_W-1:0] qn_raw;
	logic [NORM_W-1:0] qo_raw;
	logic              div_start;
	logic              div_busy;
	logic [DIV_W-1:0]  div_dividend;
	logic [DIV_W-1:0]  div_quo;
	logic [MEAN_W-1:0] mean_div;
	logic [MAG_W-1:0]  err_v;
	logic [MAG_W-1:0]  ref_v;
	logic              err_ge;
	logic [MAG_W-1:0]  mag_next;
	logic [COEF_W-1:0] coef_sel;
	logic [HI_W-1:0]   mag_hi;
	logic [15:0]       mag_lo;
	logic [CMP_W-1:0]  q_ext;
	logic [CMP_W-1:0]  lim_ext;
	logic [CMP_W-1:0]  add_ext;
	logic              forced_next;
	logic [32:0]       pe_align;
	logic              early_hit;

	assign qn_raw   = {qlen_q, 16'b0};
	assign qo_raw   = {prev_q, 16'b0};
	assign mean_div = (mean_q == '0) ? MEAN_W'(1) : mean_q;

	assign div_start = (cmd.op == OP_DIV_QN) || (cmd.op == OP_DIV_QO) ||
	                   (cmd.op == OP_DIV_PE);

	always_comb begin
		case (cmd.op)
			OP_DIV_QN: div_dividend = DIV_W'(qn_raw);
			OP_DIV_QO: div_dividend = DIV_W'(qo_raw);
			OP_DIV_PE: div_dividend = DIV_W'(prod_q);
			default:   div_dividend = '0;
		endcase
	end

	piaqm_div #(
		.DIVIDEND_W (DIV_W),
		.DIVISOR_W  (MEAN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (mean_div),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Error magnitude: subtract the smaller operand from the larger one.
	assign err_v    = (cmd.op == OP_ERR_B) ? MAG_W'(qo_q) : MAG_W'(qn_q);
	assign ref_v    = MAG_W'(ref_q);
	assign err_ge   = err_v >= ref_v;
	assign mag_next = err_ge ? (err_v - ref_v) : (ref_v - err_v);

	assign coef_sel = use_b_q ? coef_b_q : coef_a_q;
	assign mag_hi   = mag_q[MAG_W-1:16];
	assign mag_lo   = mag_q[15:0];

	assign q_ext       = CMP_W'(qlen_q);
	assign lim_ext     = CMP_W'(limit_q) & ((CMP_W'(1) << QLEN_BITS) - CMP_W'(1));
	assign add_ext     = byte_mode_q ? CMP_W'(size_q) : CMP_W'(1);
	assign forced_next = (q_ext >= lim_ext) || ((q_ext + add_ext) > lim_ext);

	assign pe_align  = 33'(pe_q) << ALIGN;
	assign early_hit = {1'b0, rand_q} < pe_align;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_mode_q  <= 1'b0;
			limit_q      <= LIMIT_RST;
			ref_q        <= REF_RST;
			coef_a_q     <= COEF_A_RST;
			coef_b_q     <= COEF_B_RST;
			mean_q       <= MEAN_RST;
			prob_q       <= '0;
			prev_q       <= '0;
			forced_cnt_q <= '0;
			early_cnt_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BYTE_MODE:   byte_mode_q <= cfg_data[0];
					REG_QUEUE_LIMIT: limit_q     <= cfg_data[LIMIT_W-1:0];
					REG_QUEUE_REF:   ref_q       <= cfg_data[REF_W-1:0];
					REG_COEF_A:      coef_a_q    <= cfg_data[COEF_W-1:0];
					REG_COEF_B:      coef_b_q    <= cfg_data[COEF_W-1:0];
					REG_MEAN_SIZE:   mean_q      <= cfg_data[MEAN_W-1:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_CLAMP: begin
					if (diff_q[ACC_W]) begin
						prob_q <= '0;
					end else if (diff_q[ACC_W-1:0] >= ACC_W'(PROB_ONE)) begin
						prob_q <= PROB_ONE;
					end else begin
						prob_q <= diff_q[PROB_W-1:0];
					end
					prev_q <= qlen_q;
				end
				OP_DROP_FORCED: forced_cnt_q <= forced_cnt_q + CNT_W'(1);
				OP_DECIDE: begin
					if (early_hit) begin
						early_cnt_q <= early_cnt_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tick_q <= op;
			qlen_q <= queue_len;
			size_q <= pkt_size;
			rand_q <= random_u;
			pos_q  <= ACC_W'(prob_q);
			neg_q  <= '0;
		end
		case (cmd.op)
			OP_TAKE_QN: qn_q <= byte_mode_q ? div_quo[NORM_W-1:0] : qn_raw;
			OP_TAKE_QO: qo_q <= byte_mode_q ? div_quo[NORM_W-1:0] : qo_raw;
			OP_ERR_A: begin
				mag_q    <= mag_next;
				to_pos_q <= err_ge;
				use_b_q  <= 1'b0;
			end
			OP_ERR_B: begin
				mag_q    <= mag_next;
				to_pos_q <= ~err_ge;
				use_b_q  <= 1'b1;
			end
			OP_MUL_HI: x_q <= T_W'(coef_sel) * T_W'(mag_hi);
			OP_MUL_LO: y_q <= Y_W'(coef_sel) * Y_W'(mag_lo);
			OP_TERM:   t_q <= (x_q + T_W'(y_q >> 16)) >> ALIGN;
			OP_ACC: begin
				if (to_pos_q) begin
					pos_q <= pos_q + ACC_W'(t_q);
				end else begin
					neg_q <= neg_q + ACC_W'(t_q);
				end
			end
			OP_DIFF:        diff_q    <= {1'b0, pos_q} - {1'b0, neg_q};
			OP_CLAMP:       verdict_q <= VERDICT_TICK;
			OP_FORCE_CHK:   forced_q  <= forced_next;
			OP_DROP_FORCED: verdict_q <= VERDICT_FORCED;
			OP_MUL_P:       prod_q    <= PROD_W'(prob_q) * PROD_W'(size_q);
			OP_TAKE_PE: begin
				if (!byte_mode_q) begin
					pe_q <= prob_q;
				end else if (div_quo > DIV_W'(PROB_ONE)) begin
					pe_q <= PROB_ONE;
				end else begin
					pe_q <= div_quo[PROB_W-1:0];
				end
			end
			OP_DECIDE: verdict_q <= early_hit ? VERDICT_EARLY : VERDICT_ACCEPT;
			OP_PUBLISH: begin
				out_verdict_q <= verdict_q;
				out_prob_q    <= prob_q;
				out_forced_q  <= forced_cnt_q;
				out_early_q   <= early_cnt_q;
			end
			default: ;
		endcase
	end

	assign sts.tick      = tick_q;
	assign sts.byte_mode = byte_mode_q;
	assign sts.forced    = forced_q;
	assign sts.div_busy  = div_busy;

	assign verdict      = out_verdict_q;
	assign prob_now     = out_prob_q;
	assign forced_total = out_forced_q;
	assign early_total  = out_early_q;

endmodule

### src/piaqm_ctrl.sv
// ============================================================================
// piaqm_ctrl: sequencer of the PI drop controller
// Takes one word at a time, steps the datapath through the tick update or
// the enqueue decision, and hands the result to the output register.
// ============================================================================
module piaqm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output piaqm_pkg::dp_cmd_t cmd,
	input  piaqm_pkg::dp_sts_t sts
);
	import piaqm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_DIV_QN,
		S_WAIT_QN,
		S_TAKE_QN,
		S_DIV_QO,
		S_WAIT_QO,
		S_TAKE_QO,
		S_ERR,
		S_MUL_HI,
		S_MUL_LO,
		S_TERM,
		S_ACC,
		S_DIFF,
		S_CLAMP,
		S_FCHK,
		S_FSEL,
		S_FDROP,
		S_MUL_P,
		S_DIV_PE,
		S_WAIT_PE,
		S_TAKE_PE,
		S_DECIDE,
		S_DONE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   out_valid_q;
	logic   term_b_q;
	logic   accept;
	logic   publish;

	assign accept  = in_valid && !busy_q;
	assign publish = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd.load = accept;
		case (state_q)
			S_DIV_QN:  cmd.op = OP_DIV_QN;
			S_TAKE_QN: cmd.op = OP_TAKE_QN;
			S_DIV_QO:  cmd.op = OP_DIV_QO;
			S_TAKE_QO: cmd.op = OP_TAKE_QO;
			S_ERR:     cmd.op = term_b_q ? OP_ERR_B : OP_ERR_A;
			S_MUL_HI:  cmd.op = OP_MUL_HI;
			S_MUL_LO:  cmd.op = OP_MUL_LO;
			S_TERM:    cmd.op = OP_TERM;
			S_ACC:     cmd.op = OP_ACC;
			S_DIFF:    cmd.op = OP_DIFF;
			S_CLAMP:   cmd.op = OP_CLAMP;
			S_FCHK:    cmd.op = OP_FORCE_CHK;
			S_FDROP:   cmd.op = OP_DROP_FORCED;
			S_MUL_P:   cmd.op = OP_MUL_P;
			S_DIV_PE:  cmd.op = OP_DIV_PE;
			S_TAKE_PE: cmd.op = OP_TAKE_PE;
			S_DECIDE:  cmd.op = OP_DECIDE;
			S_DONE:    cmd.op = publish ? OP_PUBLISH : OP_NONE;
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			term_b_q    <= 1'b0;
		end else begin
			// A new result may replace one that is taken in the same cycle.
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						busy_q  <= 1'b1;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					term_b_q <= 1'b0;
					if (sts.tick) begin
						state_q <= sts.byte_mode ? S_DIV_QN : S_TAKE_QN;
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_DIV_QN: state_q <= S_WAIT_QN;
				S_WAIT_QN: begin
					if (!sts.div_busy) begin
						state_q <= S_TAKE_QN;
					end
				end
				S_TAKE_QN: state_q <= sts.byte_mode ? S_DIV_QO : S_TAKE_QO;
				S_DIV_QO:  state_q <= S_WAIT_QO;
				S_WAIT_QO: begin
					if (!sts.div_busy) begin
						state_q <= S_TAKE_QO;
					end
				end
				S_TAKE_QO: state_q <= S_ERR;
				S_ERR:     state_q <= S_MUL_HI;
				S_MUL_HI:  state_q <= S_MUL_LO;
				S_MUL_LO:  state_q <= S_TERM;
				S_TERM:    state_q <= S_ACC;
				S_ACC: begin
					// The alpha term goes first, then the beta term.
					if (term_b_q) begin
						state_q <= S_DIFF;
					end else begin
						term_b_q <= 1'b1;
						state_q  <= S_ERR;
					end
				end
				S_DIFF:  state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_DONE;
				S_FCHK:  state_q <= S_FSEL;
				S_FSEL: begin
					if (sts.forced) begin
						state_q <= S_FDROP;
					end else begin
						state_q <= sts.byte_mode ? S_MUL_P : S_TAKE_PE;
					end
				end
				S_FDROP:  state_q <= S_DONE;
				S_MUL_P:  state_q <= S_DIV_PE;
				S_DIV_PE: state_q <= S_WAIT_PE;
				S_WAIT_PE: begin
					if (!sts.div_busy) begin
						state_q <= S_TAKE_PE;
					end
				end
				S_TAKE_PE: state_q <= S_DECIDE;
				S_DECIDE:  state_q <= S_DONE;
				S_DONE: begin
					if (publish) begin
						busy_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;

endmodule

### src/pi_aqm_drop_controller_core.sv
// ============================================================================
// pi_aqm_drop_controller_core: PI active queue management drop controller
// A sample tick updates the drop probability from the queue error; an
// enqueue word returns accept, forced drop or early drop.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    op, queue_len, pkt_size, random_u
//   out      output     out_valid / out_stall  verdict, prob_now, forced_total,
//                                              early_total
//   cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// One word is worked at a time. With D = max(QLEN_BITS+16, PROB_FRAC_BITS+17)
// (49 by default) as the width of the serial divider, byte mode divides both
// queue lengths of a tick and an enqueue's probability times packet size by
// the mean size; packet mode and a force-dropped enqueue use no division.
// A new word is taken while the previous result still waits in the output
// register; a stalled output holds its result until it is taken.
// Reset is asynchronous and puts the settings, the controller state and the
// handshake registers at their documented values.
// ============================================================================
module pi_aqm_drop_controller_core #(
	parameter int QLEN_BITS      = piaqm_pkg::QLEN_BITS_DEF,
	parameter int PROB_FRAC_BITS = piaqm_pkg::PROB_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [piaqm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [piaqm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [QLEN_BITS-1:0]              queue_len,
	input  logic [piaqm_pkg::SIZE_W-1:0]      pkt_size,
	input  logic [piaqm_pkg::RAND_W-1:0]      random_u,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [piaqm_pkg::VERDICT_W-1:0]   verdict,
	output logic [PROB_FRAC_BITS:0]           prob_now,
	output logic [piaqm_pkg::CNT_W-1:0]       forced_total,
	output logic [piaqm_pkg::CNT_W-1:0]       early_total
);
	import piaqm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	piaqm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	piaqm_dp #(
		.QLEN_BITS      (QLEN_BITS),
		.PROB_FRAC_BITS (PROB_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.queue_len    (queue_len),
		.pkt_size     (pkt_size),
		.random_u     (random_u),
		.verdict      (verdict),
		.prob_now     (prob_now),
		.forced_total (forced_total),
		.early_total  (early_total)
	);

endmodule

### src/piaqm_chk.sv
// ============================================================================
// piaqm_chk: port-level checks for the PI drop controller
// Watches the top-level ports and flags results that break the block's
// sequencing or the probability range.
// ============================================================================
module piaqm_chk #(
	parameter int QLEN_BITS      = piaqm_pkg::QLEN_BITS_DEF,
	parameter int PROB_FRAC_BITS = piaqm_pkg::PROB_FRAC_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_wr_en,
	input logic [piaqm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [piaqm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              op,
	input logic [QLEN_BITS-1:0]              queue_len,
	input logic [piaqm_pkg::SIZE_W-1:0]      pkt_size,
	input logic [piaqm_pkg::RAND_W-1:0]      random_u,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [piaqm_pkg::VERDICT_W-1:0]   verdict,
	input logic [PROB_FRAC_BITS:0]           prob_now,
	input logic [piaqm_pkg::CNT_W-1:0]       forced_total,
	input logic [piaqm_pkg::CNT_W-1:0]       early_total
);
	import piaqm_pkg::*;

	localparam logic [PROB_FRAC_BITS:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

	// The probability never leaves the range zero to one.
	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (prob_now <= PROB_ONE))
		else $error("prob_now above one");

	// An early drop needs a nonzero probability.
	a_early_needs_prob: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (verdict == VERDICT_EARLY)) |-> (prob_now != '0))
		else $error("early drop with zero probability");

	// Once a word is taken the block is busy with it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a word was taken");

	// A result only appears at the end of work on a word.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a word in work");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(verdict) &&
		$stable(prob_now) && $stable(forced_total) && $stable(early_total)))
		else $error("stalled result changed");

endmodule

bind pi_aqm_drop_controller_core piaqm_chk #(
	.QLEN_BITS      (QLEN_BITS),
	.PROB_FRAC_BITS (PROB_FRAC_BITS)
) u_piaqm_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_wr_en    (cfg_wr_en),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.op           (op),
	.queue_len    (queue_len),
	.pkt_size     (pkt_size),
	.random_u     (random_u),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.verdict      (verdict),
	.prob_now     (prob_now),
	.forced_total (forced_total),
	.early_total  (early_total)
);

### tb/tb.sv
// ============================================================================
// tb: self-checking bench for the PI drop controller core
// A queue-fed driver offers enqueue and sample-tick words through the
// valid/stall input channel, while a clocked monitor compares every result
// word field by field against an in-bench PI predictor. Settings are changed
// only between phases, once all results have drained.
// ============================================================================
module tb;
	import piaqm_pkg::*;

	localparam int QB = QLEN_BITS_DEF;
	localparam int PB = PROB_FRAC_BITS_DEF;
	localparam longint QMAX = (64'd1 << QB) - 1;
	localparam logic [127:0] P_ONE128 = 128'd1 << PB;
	localparam logic [63:0] P_ONE64 = 64'd1 << PB;
	localparam logic IN_ENQUEUE = 1'b0;
	localparam logic IN_TICK = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic op;
		logic [QB-1:0] qlen;
		logic [SIZE_W-1:0] size;
		logic [RAND_W-1:0] rnd;
	} aqm_word_t;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [PB:0] prob;
		logic [CNT_W-1:0] forced;
		logic [CNT_W-1:0] early;
	} aqm_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic [QB-1:0] queue_len = '0;
	logic [SIZE_W-1:0] pkt_size = '0;
	logic [RAND_W-1:0] random_u = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [VERDICT_W-1:0] verdict;
	logic [PB:0] prob_now;
	logic [CNT_W-1:0] forced_total;
	logic [CNT_W-1:0] early_total;

	pi_aqm_drop_controller_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .queue_len(queue_len), .pkt_size(pkt_size), .random_u(random_u),
		.out_valid(out_valid), .out_stall(out_stall),
		.verdict(verdict), .prob_now(prob_now),
		.forced_total(forced_total), .early_total(early_total)
	);

	// Predictor copy of the settings and state.
	logic m_byte_mode;
	logic [LIMIT_W-1:0] m_limit;
	logic [REF_W-1:0] m_ref;
	logic [COEF_W-1:0] m_coef_a, m_coef_b;
	logic [MEAN_W-1:0] m_mean;
	logic [PB:0] m_prob;
	logic [QB-1:0] m_prev_q;
	logic [CNT_W-1:0] m_forced, m_early;

	aqm_word_t word_backlog[$];
	aqm_result_t awaited_results[$];
	aqm_word_t cur_word;

	int err_cnt = 0;
	int gap_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int settings_used = 0;
	int n_tick = 0, n_accept = 0, n_forced = 0, n_early = 0;
	bit gaps_on = 1'b0;
	bit stalls_on = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report(input string what);
		err_cnt++;
		$display("mismatch: %s", what);
	endtask

	function automatic logic [63:0] mean_div();
		return (m_mean == 0) ? 64'd1 : {48'd0, m_mean};
	endfunction

	// Queue length in packets, Q24.16.
	function automatic logic [63:0] to_pkts(input logic [QB-1:0] q);
		logic [63:0] v;
		v = {{(48 - QB){1'b0}}, q, 16'd0};
		return m_byte_mode ? v / mean_div() : v;
	endfunction

	// coef * mag, truncated to PB fraction bits.
	function automatic logic [127:0] coef_term(input logic [31:0] coef, input logic [63:0] mag);
		logic [127:0] x, y;
		x = {96'd0, coef} * {96'd0, mag[47:16]};
		y = {96'd0, coef} * {112'd0, mag[15:0]};
		return (x + (y >> 16)) >> (32 - PB);
	endfunction

	function automatic void pi_update(input logic [QB-1:0] q);
		logic [63:0] qn, qo, r;
		logic [127:0] pos, neg, diff;
		qn = to_pkts(q);
		qo = to_pkts(m_prev_q);
		r = {32'd0, m_ref};
		pos = {{(127 - PB){1'b0}}, m_prob};
		neg = '0;
		if (qn >= r) pos = pos + coef_term(m_coef_a, qn - r);
		else neg = neg + coef_term(m_coef_a, r - qn);
		if (qo >= r) neg = neg + coef_term(m_coef_b, qo - r);
		else pos = pos + coef_term(m_coef_b, r - qo);
		if (pos > neg) begin
			diff = pos - neg;
			m_prob = (diff >= P_ONE128) ? P_ONE128[PB:0] : diff[PB:0];
		end else begin
			m_prob = '0;
		end
		m_prev_q = q;
	endfunction

	function automatic logic [VERDICT_W-1:0] admit_verdict(input logic [QB-1:0] q,
			input logic [SIZE_W-1:0] sz, input logic [RAND_W-1:0] u);
		logic [63:0] add, p, qw, lim;
		logic [VERDICT_W-1:0] res;
		add = m_byte_mode ? {48'd0, sz} : 64'd1;
		qw = {{(64 - QB){1'b0}}, q};
		lim = {40'd0, m_limit};
		if (qw >= lim || qw + add > lim) begin
			m_forced++;
			res = VERDICT_FORCED;
		end else begin
			p = {{(63 - PB){1'b0}}, m_prob};
			if (m_byte_mode) begin
				p = (p * {48'd0, sz}) / mean_div();
				if (p > P_ONE64) p = P_ONE64;
			end
			p = p << (32 - PB);
			if ({32'd0, u} < p) begin
				m_early++;
				res = VERDICT_EARLY;
			end else begin
				res = VERDICT_ACCEPT;
			end
		end
		return res;
	endfunction

	function automatic aqm_result_t predict_result(input aqm_word_t w);
		aqm_result_t res;
		if (w.op == IN_TICK) begin
			pi_update(w.qlen);
			res.verdict = VERDICT_TICK;
		end else begin
			res.verdict = admit_verdict(w.qlen, w.size, w.rnd);
		end
		res.prob = m_prob;
		res.forced = m_forced;
		res.early = m_early;
		return res;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Driver: holds a word until it is taken, then idles for a random gap.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				awaited_results.push_back(predict_result(cur_word));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (word_backlog.size() > 0) begin
					cur_word = word_backlog.pop_front();
					op <= cur_word.op;
					queue_len <= cur_word.qlen;
					pkt_size <= cur_word.size;
					random_u <= cur_word.rnd;
					in_valid <= 1'b1;
					gap_left = gaps_on ? idle_len() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_result();
		aqm_result_t want;
		if (awaited_results.size() == 0) begin
			report("result word arrived with nothing awaited");
		end else begin
			want = awaited_results.pop_front();
			if (verdict !== want.verdict)
				report($sformatf("verdict %0d, expected %0d", verdict, want.verdict));
			if (prob_now !== want.prob)
				report($sformatf("prob_now %h, expected %h", prob_now, want.prob));
			if (forced_total !== want.forced)
				report($sformatf("forced_total %0d, expected %0d", forced_total, want.forced));
			if (early_total !== want.early)
				report($sformatf("early_total %0d, expected %0d", early_total, want.early));
			case (want.verdict)
				VERDICT_TICK: n_tick++;
				VERDICT_FORCED: n_forced++;
				VERDICT_EARLY: n_early++;
				default: n_accept++;
			endcase
		end
	endtask

	// Monitor: checks taken results and drives the receiver stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				stall_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 99) >= 65) begin
				stall_left = idle_len();
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("no progress for %0d cycles", IDLE_LIMIT);
				$display("[pi_aqm_drop_controller_core] ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_BYTE_MODE: m_byte_mode = val[0];
			REG_QUEUE_LIMIT: m_limit = val[LIMIT_W-1:0];
			REG_QUEUE_REF: m_ref = val;
			REG_COEF_A: m_coef_a = val;
			REG_COEF_B: m_coef_b = val;
			REG_MEAN_SIZE: m_mean = val[MEAN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic queue_word(input logic opv, input logic [QB-1:0] q,
			input logic [SIZE_W-1:0] sz, input logic [RAND_W-1:0] u);
		aqm_word_t w;
		w.op = opv;
		w.qlen = q;
		w.size = sz;
		w.rnd = u;
		word_backlog.push_back(w);
	endtask

	task automatic drain();
		while (word_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 1 << 22);
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return m_byte_mode ? $urandom_range(40, 1500) : $urandom;
		endcase
	endfunction

	task automatic randomize_settings();
		logic [31:0] v;
		v = $urandom;
		v[0] = $urandom_range(0, 1);
		write_reg(REG_BYTE_MODE, v);
		v = $urandom;
		case ($urandom_range(0, 7))
			0: v[LIMIT_W-1:0] = '0;
			1: v[LIMIT_W-1:0] = '1;
			7: ;
			default: v[LIMIT_W-1:0] = m_byte_mode ? $urandom_range(1000, 100000)
				: $urandom_range(1, 300);
		endcase
		write_reg(REG_QUEUE_LIMIT, v);
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = $urandom;
			default: v = ($urandom_range(0, 400) << 16) | $urandom_range(0, 65535);
		endcase
		write_reg(REG_QUEUE_REF, v);
		write_reg(REG_COEF_A, pick_coef());
		write_reg(REG_COEF_B, pick_coef());
		v = $urandom;
		case ($urandom_range(0, 7))
			0: v[MEAN_W-1:0] = '0;
			1: v[MEAN_W-1:0] = 16'd1;
			2: v[MEAN_W-1:0] = '1;
			default: v[MEAN_W-1:0] = $urandom_range(40, 1500);
		endcase
		write_reg(REG_MEAN_SIZE, v);
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
		end_writes();
	endtask

	// Mostly ticks followed by bursts of enqueues around a drifting queue
	// level, so the probability gets to move; the rest is unshaped noise.
	task automatic run_random_phase(input int n_words, input bit with_hold);
		longint span, level, q, lim, step, add;
		int made, burst;
		logic [SIZE_W-1:0] sz;
		randomize_settings();
		lim = m_limit;
		span = m_byte_mode ? longint'(m_ref >> 16) * longint'(mean_div()) : longint'(m_ref >> 16);
		if (span < lim) span = lim;
		if (span < 16) span = 16;
		if (span > QMAX) span = QMAX;
		level = $urandom_range(0, span);
		made = 0;
		while (made < n_words) begin
			if ($urandom_range(0, 99) < 20) begin
				queue_word($urandom_range(0, 1), $urandom, $urandom, $urandom);
				made++;
			end else begin
				queue_word(IN_TICK, level, $urandom, $urandom);
				made++;
				burst = $urandom_range(1, 6);
				for (int i = 0; i < burst; i++) begin
					sz = pick_size();
					add = m_byte_mode ? sz : 1;
					case ($urandom_range(0, 9))
						0: q = lim;
						1: q = lim - add;
						2: q = lim - add + 1;
						default: q = level;
					endcase
					if (q < 0) q = 0;
					if (q > QMAX) q = QMAX;
					queue_word(IN_ENQUEUE, q, sz, $urandom);
					made++;
				end
				step = $urandom_range(0, span / 4 + 1);
				level = $urandom_range(0, 1) ? level + step : level - step;
				if ($urandom_range(0, 19) == 0) level = $urandom_range(0, 2 * span);
				if (level < 0) level = 0;
				if (level > QMAX) level = QMAX;
			end
		end
		if (with_hold) hold_req++;
	endtask

	initial begin
		m_byte_mode = 1'b0;
		m_limit = LIMIT_RST;
		m_ref = REF_RST;
		m_coef_a = COEF_A_RST;
		m_coef_b = COEF_B_RST;
		m_mean = MEAN_RST;
		m_prob = '0;
		m_prev_q = '0;
		m_forced = '0;
		m_early = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: packet mode, limit 25, target 50 packets.
		queue_word(IN_ENQUEUE, 0, 0, 0);
		queue_word(IN_ENQUEUE, 24, '1, 0);
		queue_word(IN_ENQUEUE, 25, 1, 0);
		queue_word(IN_ENQUEUE, '1, '1, '1);
		queue_word(IN_TICK, '1, '1, '1);
		queue_word(IN_ENQUEUE, 0, 0, '1);
		queue_word(IN_TICK, 0, '1, '1);
		queue_word(IN_ENQUEUE, 0, 0, 0);
		queue_word(IN_TICK, 50, 0, 0);
		queue_word(IN_ENQUEUE, 10, 7, 0);
		drain();

		// Byte mode with a zero mean size; the previous length stays raw.
		write_reg(REG_BYTE_MODE, 32'd1);
		write_reg(REG_QUEUE_LIMIT, 32'd1000);
		write_reg(REG_QUEUE_REF, 32'h0001_0000);
		write_reg(REG_MEAN_SIZE, 32'd0);
		end_writes();
		queue_word(IN_TICK, 3, 0, 0);
		queue_word(IN_ENQUEUE, 500, 500, '1);
		queue_word(IN_ENQUEUE, 501, 500, 0);
		queue_word(IN_ENQUEUE, 0, 0, 0);
		queue_word(IN_ENQUEUE, 1000, 0, 0);
		queue_word(IN_ENQUEUE, 999, 1, $urandom);
		drain();
		write_reg(REG_MEAN_SIZE, 32'hFFFF_FFFF);
		end_writes();
		queue_word(IN_TICK, '1, 0, 0);
		queue_word(IN_ENQUEUE, 0, '1, $urandom);
		drain();

		// Extreme settings: zero limit forces every drop, full coefficients.
		write_reg(REG_BYTE_MODE, 32'd0);
		write_reg(REG_QUEUE_LIMIT, 32'd0);
		write_reg(REG_QUEUE_REF, 32'hFFFF_FFFF);
		write_reg(REG_COEF_A, 32'hFFFF_FFFF);
		write_reg(REG_COEF_B, 32'hFFFF_FFFF);
		write_reg(REG_MEAN_SIZE, 32'd1);
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
		end_writes();
		queue_word(IN_TICK, '1, 0, 0);
		queue_word(IN_TICK, 0, 0, 0);
		queue_word(IN_ENQUEUE, 0, 0, 0);
		drain();
		write_reg(REG_QUEUE_LIMIT, 32'hFFFF_FFFF);
		write_reg(REG_QUEUE_REF, 32'd0);
		end_writes();
		queue_word(IN_TICK, '1, 0, 0);
		queue_word(IN_ENQUEUE, 24'hFFFFFE, '1, '1);
		queue_word(IN_ENQUEUE, 24'hFFFFFE, 0, 0);
		drain();

		// Random phases; each drains before the next setting, and one of
		// them holds the output off long enough to back up the input.
		for (int k = 0; k < 11; k++) begin
			gaps_on = (k % 3) != 0 && k != 4;
			stalls_on = (k % 4) != 1;
			run_random_phase(103, k == 4);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0)
			report($sformatf("%0d results never arrived", awaited_results.size()));
		$display("Ran %0d settings: %0d ticks, %0d accepted, %0d forced and %0d early drops.",
			settings_used, n_tick, n_accept, n_forced, n_early);
		$display("Input gaps, output stalls and a %0d-cycle output hold were applied.",
			HOLD_CYCLES);
		if (err_cnt == 0)
			$display("[pi_aqm_drop_controller_core] OK");
		else
			$display("[pi_aqm_drop_controller_core] ERROR");
		$finish;
	end

endmodule
